// ===== sv/itmsd_pkg.sv =====
`default_nettype none

package itmsd_pkg;

    // Record kinds on the result channel
    localparam logic [2:0] REC_STATUS = 3'd0;
    localparam logic [2:0] REC_TIP    = 3'd1;
    localparam logic [2:0] REC_HIST   = 3'd2;
    localparam logic [2:0] REC_MOVE   = 3'd3;
    localparam logic [2:0] REC_STOP   = 3'd4;

    // Input kinds
    localparam logic KIND_MEAS  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_TIP_MIN   = 3'd0;
    localparam logic [2:0] CFG_TIP_ANGLE = 3'd1;
    localparam logic [2:0] CFG_MOVE_MIN  = 3'd2;
    localparam logic [2:0] CFG_MOVE_THR  = 3'd3;
    localparam logic [2:0] CFG_STOP_MIN  = 3'd4;
    localparam logic [2:0] CFG_STOP_THR  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Angle limits in hundredths of a degree
    localparam logic [16:0]        TIP_ROLL_LIMIT = 17'd9000;
    localparam logic signed [17:0] HALF_TURN      = 18'sd18000;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
        logic [31:0]        sample_time;
    } t_sample;

    typedef struct packed {
        logic [2:0]         record_kind;
        logic               tipped;
        logic               moving;
        logic               tip_side;
        logic [31:0]        start_time;
        logic signed [15:0] hist_roll;
        logic signed [15:0] hist_pitch;
        logic signed [15:0] hist_accel_x;
        logic signed [15:0] hist_accel_z;
        logic [31:0]        hist_time;
        logic               last_of_run;
    } t_record;

    // One ring entry
    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
        logic [31:0]        sample_time;
    } t_hist;

    // Work handed from the front to the back for one input
    typedef struct packed {
        logic        clear_only;
        logic        tip_ev;
        logic        tip_side;
        logic [31:0] tip_time;
        logic        move_ev;
        logic [31:0] move_time;
        logic        stop_ev;
        logic [31:0] stop_time;
        logic        tipped;
        logic        moving;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/itmsd_ifs.sv =====
`default_nettype none

interface itmsd_smp_if;
    logic               valid;
    logic               ready;
    itmsd_pkg::t_sample data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

interface itmsd_rec_if;
    logic               valid;
    logic               ready;
    itmsd_pkg::t_record data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/itmsd_front.sv =====
`default_nettype none

module itmsd_front #(
    parameter int HISTORY_DEPTH = 16,
    parameter int PW = 4,
    parameter int FW = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [itmsd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [itmsd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_valid,
    input  wire itmsd_pkg::t_sample                  i_data,
    output logic                                     o_ready,
    input  wire logic                                i_q_full,
    input  wire logic                                i_hist_done,
    output logic                                     o_push,
    output itmsd_pkg::t_job                          o_job,
    output logic                                     o_wr_en,
    output logic [PW-1:0]                            o_wr_addr,
    output itmsd_pkg::t_hist                         o_wr_data,
    output logic [PW-1:0]                            o_oldest
);

    logic [15:0] r_tip_min, r_move_min, r_stop_min;
    logic [14:0] r_tip_thr, r_move_thr, r_stop_thr;

    logic [FW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [15:0]   r_tip_cnt, n_tip_cnt, r_move_cnt, n_move_cnt, r_stop_cnt, n_stop_cnt;
    logic [31:0]   r_tip_t, n_tip_t, r_move_t, n_move_t, r_stop_t, n_stop_t;
    logic          r_tipped, n_tipped, r_moving, n_moving;
    logic          r_lock;

    logic              accept, meas;
    logic signed [16:0] roll_x, pitch_x, az_x;
    logic [16:0]       roll_abs, pitch_abs;
    logic              tip_q, move_q, stop_q;
    logic              tip_ev, move_ev, stop_ev;

    // Hold intake while the job queue is full or a history dump still has to read the ring
    assign o_ready = !i_q_full && !r_lock;
    assign accept  = i_valid && o_ready;
    assign meas    = (i_data.kind == itmsd_pkg::KIND_MEAS);

    always_comb begin
        roll_x    = 17'(i_data.roll);
        pitch_x   = 17'(i_data.pitch);
        az_x      = 17'(i_data.accel_z);
        roll_abs  = roll_x[16] ? 17'(-roll_x) : 17'(roll_x);
        pitch_abs = pitch_x[16] ? 17'(-pitch_x) : 17'(pitch_x);

        if (roll_abs > itmsd_pkg::TIP_ROLL_LIMIT) begin
            tip_q = pitch_abs < {2'b00, r_tip_thr};
        end else begin
            tip_q = $signed({1'b0, pitch_abs})
                  > (itmsd_pkg::HALF_TURN - $signed({3'b000, r_tip_thr}));
        end
        move_q = az_x > $signed({2'b00, r_move_thr});
        stop_q = az_x < -$signed({2'b00, r_stop_thr});
    end

    always_comb begin
        n_fill     = r_fill;
        n_wr_ptr   = r_wr_ptr;
        n_tip_cnt  = r_tip_cnt;
        n_move_cnt = r_move_cnt;
        n_stop_cnt = r_stop_cnt;
        n_tip_t    = r_tip_t;
        n_move_t   = r_move_t;
        n_stop_t   = r_stop_t;
        n_tipped   = r_tipped;
        n_moving   = r_moving;
        tip_ev     = 1'b0;
        move_ev    = 1'b0;
        stop_ev    = 1'b0;

        if (!meas) begin
            n_fill   = '0;
            n_wr_ptr = '0;
        end else begin
            n_fill   = (r_fill == FW'(HISTORY_DEPTH)) ? r_fill : r_fill + 1'b1;
            n_wr_ptr = (r_wr_ptr == PW'(HISTORY_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;

            if (tip_q) begin
                if (r_tip_cnt == '0) n_tip_t = i_data.sample_time;
                if (r_tip_cnt != itmsd_pkg::COUNT_MAX) n_tip_cnt = r_tip_cnt + 1'b1;
            end else begin
                n_tip_cnt = '0;
            end
            if (move_q) begin
                if (r_move_cnt == '0) n_move_t = i_data.sample_time;
                if (r_move_cnt != itmsd_pkg::COUNT_MAX) n_move_cnt = r_move_cnt + 1'b1;
            end else begin
                n_move_cnt = '0;
            end
            if (stop_q) begin
                if (r_stop_cnt == '0) n_stop_t = i_data.sample_time;
                if (r_stop_cnt != itmsd_pkg::COUNT_MAX) n_stop_cnt = r_stop_cnt + 1'b1;
            end else begin
                n_stop_cnt = '0;
            end

            tip_ev   = (n_tip_cnt >= r_tip_min) && (n_fill == FW'(HISTORY_DEPTH));
            move_ev  = n_move_cnt >= r_move_min;
            stop_ev  = n_stop_cnt >= r_stop_min;
            n_tipped = tip_ev;
            n_moving = move_ev && !stop_ev;
        end
    end

    always_comb begin
        o_job.clear_only = !meas;
        o_job.tip_ev     = tip_ev;
        o_job.tip_side   = i_data.accel_x[15] || (i_data.accel_x == '0);
        o_job.tip_time   = n_tip_t;
        o_job.move_ev    = move_ev;
        o_job.move_time  = n_move_t;
        o_job.stop_ev    = stop_ev;
        o_job.stop_time  = n_stop_t;
        o_job.tipped     = n_tipped;
        o_job.moving     = n_moving;
    end

    assign o_push    = accept;
    assign o_wr_en   = accept && meas;
    assign o_wr_addr = r_wr_ptr;
    assign o_wr_data = '{roll: i_data.roll, pitch: i_data.pitch, accel_x: i_data.accel_x,
                         accel_z: i_data.accel_z, sample_time: i_data.sample_time};
    // Stable while locked, so it marks the oldest entry of a pending dump
    assign o_oldest  = r_wr_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tip_min  <= 16'd1;
            r_tip_thr  <= 15'd4500;
            r_move_min <= 16'd1;
            r_move_thr <= '0;
            r_stop_min <= 16'd1;
            r_stop_thr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                itmsd_pkg::CFG_TIP_MIN:   r_tip_min  <= i_cfg_data;
                itmsd_pkg::CFG_TIP_ANGLE: r_tip_thr  <= i_cfg_data[14:0];
                itmsd_pkg::CFG_MOVE_MIN:  r_move_min <= i_cfg_data;
                itmsd_pkg::CFG_MOVE_THR:  r_move_thr <= i_cfg_data[14:0];
                itmsd_pkg::CFG_STOP_MIN:  r_stop_min <= i_cfg_data;
                itmsd_pkg::CFG_STOP_THR:  r_stop_thr <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_wr_ptr   <= '0;
            r_tip_cnt  <= '0;
            r_move_cnt <= '0;
            r_stop_cnt <= '0;
            r_tip_t    <= '0;
            r_move_t   <= '0;
            r_stop_t   <= '0;
            r_tipped   <= 1'b0;
            r_moving   <= 1'b0;
            r_lock     <= 1'b0;
        end else begin
            if (accept) begin
                r_fill     <= n_fill;
                r_wr_ptr   <= n_wr_ptr;
                r_tip_cnt  <= n_tip_cnt;
                r_move_cnt <= n_move_cnt;
                r_stop_cnt <= n_stop_cnt;
                r_tip_t    <= n_tip_t;
                r_move_t   <= n_move_t;
                r_stop_t   <= n_stop_t;
                r_tipped   <= n_tipped;
                r_moving   <= n_moving;
            end
            if (accept && tip_ev) begin
                r_lock <= 1'b1;
            end else if (i_hist_done) begin
                r_lock <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/itmsd_job_fifo.sv =====
`default_nettype none

module itmsd_job_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire itmsd_pkg::t_job i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output itmsd_pkg::t_job      o_job
);

    itmsd_pkg::t_job r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/itmsd_back.sv =====
`default_nettype none

module itmsd_back #(
    parameter int HISTORY_DEPTH = 16,
    parameter int PW = 4,
    parameter int FW = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [PW-1:0]     i_wr_addr,
    input  wire itmsd_pkg::t_hist  i_wr_data,
    input  wire logic [PW-1:0]     i_oldest,
    input  wire logic              i_q_empty,
    input  wire itmsd_pkg::t_job   i_job,
    output logic                   o_pop,
    output logic                   o_hist_done,
    output logic                   o_valid,
    output itmsd_pkg::t_record     o_data,
    input  wire logic              i_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TIP  = 3'd1;
    localparam logic [2:0] S_HRD  = 3'd2;
    localparam logic [2:0] S_HOUT = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;
    localparam logic [2:0] S_STOP = 3'd5;
    localparam logic [2:0] S_STAT = 3'd6;

    itmsd_pkg::t_hist   r_ring [HISTORY_DEPTH];
    itmsd_pkg::t_hist   r_rd_q;
    itmsd_pkg::t_job    r_job;
    itmsd_pkg::t_record r_out, n_rec;
    logic               r_out_valid;
    logic [2:0]         r_state, n_state;
    logic [PW-1:0]      r_rd_ptr;
    logic [FW-1:0]      r_idx;
    logic               slot_free, load, rd_en;
    logic [2:0]         after_hist;

    assign slot_free = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_comb begin
        if (r_job.move_ev)      after_hist = S_MOVE;
        else if (r_job.stop_ev) after_hist = S_STOP;
        else                    after_hist = S_STAT;
    end

    always_comb begin
        n_state     = r_state;
        load        = 1'b0;
        rd_en       = 1'b0;
        o_pop       = 1'b0;
        o_hist_done = 1'b0;
        n_rec       = '0;
        n_rec.tipped = r_job.tipped;
        n_rec.moving = r_job.moving;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_job.clear_only)   n_state = S_STAT;
                    else if (i_job.tip_ev)  n_state = S_TIP;
                    else if (i_job.move_ev) n_state = S_MOVE;
                    else if (i_job.stop_ev) n_state = S_STOP;
                    else                    n_state = S_STAT;
                end
            end
            S_TIP: begin
                n_rec.record_kind = itmsd_pkg::REC_TIP;
                n_rec.tip_side    = r_job.tip_side;
                n_rec.start_time  = r_job.tip_time;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                rd_en   = 1'b1;
                n_state = S_HOUT;
            end
            S_HOUT: begin
                n_rec.record_kind  = itmsd_pkg::REC_HIST;
                n_rec.hist_roll    = r_rd_q.roll;
                n_rec.hist_pitch   = r_rd_q.pitch;
                n_rec.hist_accel_x = r_rd_q.accel_x;
                n_rec.hist_accel_z = r_rd_q.accel_z;
                n_rec.hist_time    = r_rd_q.sample_time;
                if (slot_free) begin
                    load = 1'b1;
                    if (r_idx == FW'(HISTORY_DEPTH - 1)) begin
                        o_hist_done = 1'b1;
                        n_state     = after_hist;
                    end else begin
                        n_state = S_HRD;
                    end
                end
            end
            S_MOVE: begin
                n_rec.record_kind = itmsd_pkg::REC_MOVE;
                n_rec.start_time  = r_job.move_time;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = r_job.stop_ev ? S_STOP : S_STAT;
                end
            end
            S_STOP: begin
                n_rec.record_kind = itmsd_pkg::REC_STOP;
                n_rec.start_time  = r_job.stop_time;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                n_rec.record_kind = itmsd_pkg::REC_STATUS;
                n_rec.last_of_run = 1'b1;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // History ring: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_ring[i_wr_addr] <= i_wr_data;
        if (rd_en)   r_rd_q <= r_ring[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (load)  r_out <= n_rec;
        if (r_state == S_TIP) begin
            r_rd_ptr <= i_oldest;
            r_idx    <= '0;
        end else if (r_state == S_HOUT && load) begin
            r_rd_ptr <= (r_rd_ptr == PW'(HISTORY_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            r_idx    <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load)         r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/imu_tip_motion_stop_detector_top.sv =====
// IMU tip, motion and stop detector.
// i_smp carries one transaction per input: a measurement (roll, pitch, x and z
// acceleration, timestamp) or a request to clear the history ring. o_rec
// carries the result records; the status record, flagged by last_of_run,
// always closes the records of one input. Both use valid/ready.
// The front takes one transaction per cycle into a two-entry job queue while
// the queue has room; it holds intake from the transaction that raises a
// tipping event until its history dump has read the whole ring.
// The back turns a job into records through an output register; for a tipping
// event every history entry costs one ring read and one output load.
// A job passes the job queue and the back's idle state before its first
// record is loaded into the output register.
// When the receiver stalls, the output register holds its record, the back
// waits, the queue fills and then i_smp.ready drops; nothing is dropped.
// Reset (synchronous, active low) restores register defaults, empties the
// ring, clears counters and flags; the ring contents need no clearing pass.
// Configuration writes on i_cfg_* take effect at once and belong in idle time.
`default_nettype none

module imu_tip_motion_stop_detector_top #(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [itmsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [itmsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    itmsd_smp_if.snk                              i_smp,
    itmsd_rec_if.src                              o_rec
);

    // Ring pointer and fill count widths
    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic              q_full, q_empty, push, pop, hist_done, wr_en;
    logic [PW-1:0]     wr_addr, oldest;
    itmsd_pkg::t_hist  wr_data;
    itmsd_pkg::t_job   job_in, job_out;
    logic              front_ready, back_valid;
    itmsd_pkg::t_record back_data;

    // Classify each transaction and update the detectors
    itmsd_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PW            (PW),
        .FW            (FW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_smp.valid),
        .i_data      (i_smp.data),
        .o_ready     (front_ready),
        .i_q_full    (q_full),
        .i_hist_done (hist_done),
        .o_push      (push),
        .o_job       (job_in),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_oldest    (oldest)
    );

    assign i_smp.ready = front_ready;

    // Decouple classification from record output
    itmsd_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    // Emit records, including the history dump from the ring
    itmsd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PW            (PW),
        .FW            (FW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_oldest    (oldest),
        .i_q_empty   (q_empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_hist_done (hist_done),
        .o_valid     (back_valid),
        .o_data      (back_data),
        .i_ready     (o_rec.ready)
    );

    assign o_rec.valid = back_valid;
    assign o_rec.data  = back_data;

endmodule

`default_nettype wire
